/* sv/rmh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmh_pkg
// Shared types for the two-heap running median core.
// ----------------------------------------------------------------------------
package rmh_pkg;

  localparam int CNT_W = 11;  // held_count field width

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_RT_RD,
    ST_RT_CMP,
    ST_UP_RD,
    ST_UP_CMP,
    ST_TOP_RD,
    ST_TOP_WAIT,
    ST_MED,
    ST_OUT
  } state_e;

endpackage

/* sv/rmh_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmh_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module rmh_ram #(
  parameter int Width = 16,
  parameter int Depth = 512
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [Width-1:0]                         wdata_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

/* sv/running_median_two_heaps_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_median_two_heaps_core
// Running median of a signed stream using a max-heap and a min-heap in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: tdata = sample, tuser = restart (empties both heaps first).
//   m_axis: tdata = median_value, held_count, dropped from bit 0 up.
//   One result item per input item. One item is worked on at a time.
//   Each heap sits in its own single-port RAM. A sift-down level takes two
//   child reads, two compares and one write, a sift-up level a parent read,
//   then a compare and write. A dropped sample goes straight to the output.
//   At CAPACITY 1024 an insert at worst sifts down nine levels of one heap,
//   then up nine of the other. The next item is taken in the cycle after
//   the result is registered.
//   Reset empties both heaps (sizes zero, median zero); no clearing pass.
//   A result waits in the output register while m_axis_tready is low; the
//   next item is still taken, and its result waits until the first leaves.
// ----------------------------------------------------------------------------
module running_median_two_heaps_core #(
  parameter int CAPACITY     = 1024,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,  // sample
  input  logic                    s_axis_tuser,  // restart
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // median_value, held_count, dropped
  output logic [((SAMPLE_WIDTH+rmh_pkg::CNT_W+1+7)/8)*8-1:0] m_axis_tdata
);
  import rmh_pkg::*;

  localparam int HeapDepth = (CAPACITY + 1) / 2;
  localparam int AW        = (HeapDepth > 1) ? $clog2(HeapDepth) : 1;
  localparam int SzW       = AW + 1;
  localparam int CntW      = CNT_W;
  localparam int SW        = SAMPLE_WIDTH;
  localparam int OutW      = ((SW + CntW + 1 + 7) / 8) * 8;

  state_e state_q, state_d;
  logic [SzW-1:0] lsz_q, lsz_d, usz_q, usz_d;
  logic signed [SW-1:0] med_q, med_d, x_q, x_d, val_q, val_d;
  logic [AW-1:0] pos_q, pos_d, sel_q, sel_d;
  logic [SzW-1:0] dsz_q, dsz_d;   // size of the heap being sifted down
  logic dmax_q, dmax_d;           // sift-down heap is the max (lower) heap
  logic umax_q, umax_d;           // sift-up heap is the max heap
  logic drop_q, drop_d;
  logic signed [SW-1:0] best_q, best_d, ltop_q, ltop_d;
  logic [1:0] ph_q, ph_d;         // child read phase in sift down
  logic ovalid_q, ovalid_d;
  logic [OutW-1:0] odata_q, odata_d;

  logic lwe, uwe;
  logic [AW-1:0] laddr, uaddr;
  logic [SW-1:0] lwd, uwd, lrd, urd;

  rmh_ram #(.Width(SW), .Depth(HeapDepth)) u_lower (
    .clk_i, .we_i(lwe), .addr_i(laddr), .wdata_i(lwd), .rdata_o(lrd));
  rmh_ram #(.Width(SW), .Depth(HeapDepth)) u_upper (
    .clk_i, .we_i(uwe), .addr_i(uaddr), .wdata_i(uwd), .rdata_o(urd));

  logic signed [SW-1:0] rd_d, rd_u;
  logic [SzW:0] total;
  logic signed [SW:0] hsum;
  logic [AW:0] lch;

  function automatic logic above(logic signed [SW-1:0] a, logic signed [SW-1:0] b,
                                 logic is_max);
    above = is_max ? (a > b) : (a < b);
  endfunction

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign total = {1'b0, lsz_q} + {1'b0, usz_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lsz_q <= '0;
      usz_q <= '0;
      med_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      lsz_q <= lsz_d;
      usz_q <= usz_d;
      med_q <= med_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; val_q <= val_d; pos_q <= pos_d; sel_q <= sel_d;
    dsz_q <= dsz_d; dmax_q <= dmax_d; umax_q <= umax_d;
    drop_q <= drop_d; best_q <= best_d; ltop_q <= ltop_d; ph_q <= ph_d;
    odata_q <= odata_d;
  end

  always_comb begin
    state_d = state_q; lsz_d = lsz_q; usz_d = usz_q; med_d = med_q;
    x_d = x_q; val_d = val_q; pos_d = pos_q; sel_d = sel_q; dsz_d = dsz_q;
    dmax_d = dmax_q; umax_d = umax_q; drop_d = drop_q;
    best_d = best_q; ltop_d = ltop_q; ph_d = ph_q;
    ovalid_d = ovalid_q; odata_d = odata_q;
    lwe = 1'b0; uwe = 1'b0; laddr = pos_q; uaddr = pos_q;
    lwd = val_q; uwd = val_q;
    rd_d = dmax_q ? lrd : urd;
    rd_u = umax_q ? lrd : urd;
    hsum = '0;
    lch = '0;
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          x_d = s_axis_tdata[SW-1:0];
          if (s_axis_tuser) begin
            lsz_d = '0; usz_d = '0; med_d = '0;
          end
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        drop_d = 1'b0;
        if ({{(32-SzW-1){1'b0}}, total} >= 32'(CAPACITY)) begin
          drop_d = 1'b1;
          state_d = ST_OUT;
        end else if (lsz_q < usz_q) begin
          umax_d = 1'b1;
          if (x_q <= med_q) begin
            val_d = x_q; pos_d = lsz_q[AW-1:0]; state_d = ST_UP_RD;
            lsz_d = lsz_q + 1'b1;
          end else begin
            dmax_d = 1'b0; dsz_d = usz_q; pos_d = '0; val_d = x_q;
            ph_d = 2'd0; state_d = ST_RT_RD; uaddr = '0;
          end
        end else if (lsz_q > usz_q) begin
          umax_d = 1'b0;
          if (x_q >= med_q) begin
            val_d = x_q; pos_d = usz_q[AW-1:0]; state_d = ST_UP_RD;
            usz_d = usz_q + 1'b1;
          end else begin
            dmax_d = 1'b1; dsz_d = lsz_q; pos_d = '0; val_d = x_q;
            ph_d = 2'd0; state_d = ST_RT_RD; laddr = '0;
          end
        end else begin
          umax_d = (x_q < med_q);
          val_d = x_q;
          if (x_q < med_q) begin
            pos_d = lsz_q[AW-1:0]; lsz_d = lsz_q + 1'b1;
          end else begin
            pos_d = usz_q[AW-1:0]; usz_d = usz_q + 1'b1;
          end
          state_d = ST_UP_RD;
        end
      end
      // Sift down: ph 0 reads top (old value, kept), then children left/right.
      ST_RT_RD: begin
        lch = {pos_q, 1'b1};
        laddr = (ph_q == 2'd2) ? lch[AW-1:0] + 1'b1 : lch[AW-1:0];
        if (ph_q == 2'd0) laddr = '0;
        uaddr = laddr;
        state_d = ST_RT_CMP;
      end
      ST_RT_CMP: begin
        lch = {pos_q, 1'b1};
        case (ph_q)
          2'd0: begin
            ltop_d = rd_d;  // displaced top
            best_d = val_q; sel_d = pos_q; ph_d = 2'd1;
            state_d = ST_RT_RD;
            if ({{(SzW-AW-1+1){1'b0}}, lch} >= {1'b0, dsz_q}) begin
              ph_d = 2'd3; state_d = ST_RT_CMP;
            end
          end
          2'd1: begin
            if (above(rd_d, best_q, dmax_q)) begin
              best_d = rd_d; sel_d = lch[AW-1:0];
            end
            ph_d = 2'd2; state_d = ST_RT_RD;
            if ({{(SzW-AW){1'b0}}, lch} + 1'b1 >= {1'b0, dsz_q}) begin
              ph_d = 2'd3; state_d = ST_RT_CMP;
            end
          end
          2'd2: begin
            if (above(rd_d, best_q, dmax_q)) begin
              best_d = rd_d; sel_d = lch[AW-1:0] + 1'b1;
            end
            ph_d = 2'd3;
          end
          default: begin
            // write best at pos; continue at sel with val, or end and sift the displaced top up the other heap
            lwd = best_q; uwd = best_q;
            lwe = dmax_q; uwe = !dmax_q;
            if (sel_q == pos_q) begin
              val_d = ltop_q; umax_d = !dmax_q;
              if (dmax_q) begin
                pos_d = usz_q[AW-1:0]; usz_d = usz_q + 1'b1;
              end else begin
                pos_d = lsz_q[AW-1:0]; lsz_d = lsz_q + 1'b1;
              end
              state_d = ST_UP_RD;
            end else begin
              pos_d = sel_q; ph_d = 2'd1; best_d = val_q;
              state_d = ST_RT_RD;
              lch = {sel_q, 1'b1};
              if ({{(SzW-AW-1+1){1'b0}}, lch} >= {1'b0, dsz_q}) begin
                ph_d = 2'd3; state_d = ST_RT_CMP;
              end
            end
          end
        endcase
      end
      // Sift up: hole at pos, value val; read parent, move it down if needed.
      ST_UP_RD: begin
        if (pos_q == '0) begin
          lwe = umax_q; uwe = !umax_q; state_d = ST_TOP_RD;
        end else begin
          laddr = (pos_q - 1'b1) >> 1; uaddr = laddr;
          state_d = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        laddr = pos_q; uaddr = pos_q;
        if (above(val_q, rd_u, umax_q)) begin
          lwd = rd_u; uwd = rd_u; lwe = umax_q; uwe = !umax_q;
          pos_d = (pos_q - 1'b1) >> 1;
          state_d = ST_UP_RD;
        end else begin
          lwe = umax_q; uwe = !umax_q; state_d = ST_TOP_RD;
        end
      end
      ST_TOP_RD: begin
        laddr = '0; uaddr = '0; state_d = ST_TOP_WAIT;
      end
      ST_TOP_WAIT: begin
        ltop_d = lrd; best_d = urd; state_d = ST_MED;
      end
      ST_MED: begin
        hsum = {ltop_q[SW-1], ltop_q} + {best_q[SW-1], best_q};
        if (lsz_q == usz_q) med_d = hsum[SW:1];
        else if (lsz_q > usz_q) med_d = ltop_q;
        else med_d = best_q;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ovalid_q || m_axis_tready) begin
          odata_d = '0;
          odata_d[SW-1:0] = med_q;
          odata_d[SW +: CntW] = CntW'(total);
          odata_d[SW+CntW] = drop_q;
          ovalid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* sv/rmh_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmh_checker
// Port-level checks for the running median core.
// ----------------------------------------------------------------------------
module rmh_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("out dropped");
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (!m_axis_tvalid || m_axis_tready)
    |=> !m_axis_tvalid) else $error("result too early");
  a_one_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("two items in flight");

endmodule

bind running_median_two_heaps_core rmh_checker u_rmh_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready);
